// ===== hdl/isr_pkg.sv =====
// constants and register codes shared by the record insertion sorter
// no dependencies; compiled first
package isr_pkg;

  localparam int KEY_W      = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_DESCENDING  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_KEY_IS_NAME = cfg_idx_t'(1);

endpackage

// ===== hdl/isr_if.sv =====
// valid/ready channel interfaces of the record insertion sorter
// depends on isr_pkg
interface isr_rec_if #(parameter int TAG_BITS = 8);
  logic                      valid;
  logic                      ready;
  logic [isr_pkg::KEY_W-1:0] sort_key;
  logic [TAG_BITS-1:0]       record_tag;
  logic                      last_record;

  modport source (output valid, sort_key, record_tag, last_record, input ready);
  modport sink   (input valid, sort_key, record_tag, last_record, output ready);
endinterface

interface isr_res_if #(parameter int TAG_BITS = 8);
  logic                      valid;
  logic                      ready;
  logic [isr_pkg::KEY_W-1:0] out_key;
  logic [TAG_BITS-1:0]       out_tag;
  logic                      out_last;
  logic                      dropped;

  modport source (output valid, out_key, out_tag, out_last, dropped, input ready);
  modport sink   (input valid, out_key, out_tag, out_last, dropped, output ready);
endinterface

interface isr_cfg_if;
  logic                           valid;
  logic                           ready;
  isr_pkg::cfg_idx_t              index;
  logic [isr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/insertion_sort_records.sv =====
// record insertion sorter: a record moves a hole down the store, a read (S_INS_RD) and a
// compare-write (S_INS_CMP) per stored entry shifted, in the single loop on the ram; no new record
// is taken until the last one is in; a record on a full store is dropped; after the last record a run
// emits each beat through S_EMIT_RD, S_EMIT_LD and S_EMIT_OUT, read from the ram and registered,
// holding in S_EMIT_OUT until the beat is taken; sync active-high reset clears fill count, overflow
// flag, registers and handshake state; store contents are not cleared, only the first fill-count entries are ever read
module insertion_sort_records #(
  parameter int MAX_RECORDS = 64,
  parameter int TAG_BITS    = 8
) (
  input logic        clk,
  input logic        rst,
  isr_cfg_if.sink    cfg,
  isr_rec_if.sink    rec,
  isr_res_if.source  res
);

  localparam int ADDR_W  = $clog2(MAX_RECORDS);
  localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
  localparam int ENTRY_W = isr_pkg::KEY_W + TAG_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;  // read the entry below the hole, or write in at the bottom
  localparam logic [2:0] S_INS_CMP  = 3'd2;  // compare, then shift up or drop in
  localparam logic [2:0] S_EMIT_RD  = 3'd3;
  localparam logic [2:0] S_EMIT_LD  = 3'd4;
  localparam logic [2:0] S_EMIT_OUT = 3'd5;

  logic [2:0]                state;
  logic [CNT_W-1:0]          fill;
  logic                      overflow;
  logic [ADDR_W-1:0]         pos;        // current hole in the store
  logic [CNT_W-1:0]          emit_idx;
  logic [isr_pkg::KEY_W-1:0] key_q;
  logic [TAG_BITS-1:0]       tag_q;
  logic                      last_q;
  logic                      descending;
  logic                      key_is_name;

  // output register
  logic                      out_valid;
  logic [isr_pkg::KEY_W-1:0] out_key_q;
  logic [TAG_BITS-1:0]       out_tag_q;
  logic                      out_last_q;
  logic                      dropped_q;

  // ram port
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]        ram_rdata;

  logic [isr_pkg::KEY_W-1:0] held_key;
  logic                      goes_before;
  logic                      in_beat;
  logic                      out_beat;
  logic                      emit_last;

  // one memory holds key and tag side by side
  isr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign held_key = ram_rdata[ENTRY_W-1 -: isr_pkg::KEY_W];

  // new key stands before the held one; descending name order puts a new key before equal held keys
  always_comb begin
    if (!descending) begin
      goes_before = key_q < held_key;
    end else if (key_is_name) begin
      goes_before = key_q >= held_key;
    end else begin
      goes_before = key_q > held_key;
    end
  end

  assign in_beat   = rec.valid && rec.ready;
  assign out_beat  = res.valid && res.ready;
  assign emit_last = (emit_idx + CNT_W'(1)) == fill;

  assign rec.ready    = (state == S_IDLE);
  assign cfg.ready    = (state == S_IDLE);
  assign res.valid    = out_valid;
  assign res.out_key  = out_key_q;
  assign res.out_tag  = out_tag_q;
  assign res.out_last = out_last_q;
  assign res.dropped  = dropped_q;

  // ram access per state: reads and writes of one step never hit the same entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = {key_q, tag_q};
    ram_re    = 1'b0;
    ram_raddr = pos - ADDR_W'(1);
    case (state)
      S_INS_RD: begin
        if (pos == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (goes_before) begin
          ram_wdata = ram_rdata;   // shift the held entry up into the hole
        end
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = emit_idx[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      overflow    <= 1'b0;
      emit_idx    <= '0;
      out_valid   <= 1'b0;
      descending  <= 1'b0;
      key_is_name <= 1'b0;
    end else begin
      // register writes, taken only while idle
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          isr_pkg::REG_DESCENDING:  descending  <= cfg.data[0];
          isr_pkg::REG_KEY_IS_NAME: key_is_name <= cfg.data[0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            key_q  <= rec.sort_key;
            tag_q  <= rec.record_tag;
            last_q <= rec.last_record;
            pos    <= fill[ADDR_W-1:0];
            if (fill == CNT_W'(MAX_RECORDS)) begin
              // store full: drop the record, still emit on a last one
              overflow <= 1'b1;
              emit_idx <= '0;
              state    <= rec.last_record ? S_EMIT_RD : S_IDLE;
            end else begin
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            fill     <= fill + CNT_W'(1);
            emit_idx <= '0;
            state    <= last_q ? S_EMIT_RD : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (goes_before) begin
            pos   <= pos - ADDR_W'(1);
            state <= S_INS_RD;
          end else begin
            fill     <= fill + CNT_W'(1);
            emit_idx <= '0;
            state    <= last_q ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid  <= 1'b1;
          out_key_q  <= held_key;
          out_tag_q  <= ram_rdata[TAG_BITS-1:0];
          out_last_q <= emit_last;
          dropped_q  <= overflow;
          state      <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_beat) begin
            out_valid <= 1'b0;
            if (out_last_q) begin
              // run done: empty the store for the next set
              fill     <= '0;
              overflow <= 1'b0;
              emit_idx <= '0;
              state    <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + CNT_W'(1);
              state    <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no record is taken while a result beat waits
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> !res.valid)
    else $error("record accepted while a result is pending");

  // fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_RECORDS))
    else $error("fill count beyond capacity");

  // the final beat of a run leaves an empty store and a clear drop flag
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    out_beat && res.out_last |=> fill == '0 && !overflow)
    else $error("store not cleared after run");

  // a drop flag never shows unless the store was full
  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.dropped |-> fill == CNT_W'(MAX_RECORDS))
    else $error("dropped flag with room left");

endmodule

// ===== hdl/isr_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module isr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
